// File: design/tlvse_pkg.sv
// ---------------------------------------------------------------------------
// tlvse_pkg: shared types and constants
// Register indexes, status codes, field widths and the result record of the
// envelope section extractor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tlvse_pkg;

  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 21;
  localparam int unsigned PosW     = 21;
  localparam int unsigned HdrBytes = 8;

  localparam logic [PosW-1:0] PosMax = {PosW{1'b1}};

  // register indexes
  localparam logic [CfgIdxW-1:0] CFG_EXPECTED_VERSION = 4'd0;
  localparam logic [CfgIdxW-1:0] CFG_SECURITY_TAG     = 4'd1;
  localparam logic [CfgIdxW-1:0] CFG_CRITICAL_MASK    = 4'd2;
  localparam logic [CfgIdxW-1:0] CFG_MAX_BYTES        = 4'd3;

  // status codes
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_ENV_INVALID  = 3'd1;
  localparam logic [2:0] ST_VERSION      = 3'd2;
  localparam logic [2:0] ST_TRUNCATED    = 3'd3;
  localparam logic [2:0] ST_SECTION      = 3'd4;
  localparam logic [2:0] ST_SEC_EMPTY    = 3'd5;
  localparam logic [2:0] ST_CRITICAL     = 3'd6;

  typedef struct packed {
    logic [15:0]     expected_version;
    logic [15:0]     security_tag;
    logic [15:0]     critical_mask;
    logic [PosW-1:0] max_bytes;
  } cfg_regs_t;

  typedef struct packed {
    logic [7:0] sec_byte;
    logic       sec_valid;
    logic       sec_first;
    logic       done_res;
    logic [2:0] status;
  } result_t;

endpackage

`default_nettype wire

// File: design/tlvse_if.sv
// ---------------------------------------------------------------------------
// tlvse_if: channel interfaces
// Byte input channel, result channel and register write channel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tlvse_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_byte;
  logic       empty_blob;

  modport source (output valid, byte_value, last_byte, empty_blob, input ready);
  modport sink   (input valid, byte_value, last_byte, empty_blob, output ready);
endinterface

interface tlvse_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] sec_byte;
  logic       sec_valid;
  logic       sec_first;
  logic       done_res;
  logic [2:0] status;

  modport source (output valid, sec_byte, sec_valid, sec_first, done_res, status,
                  input ready);
  modport sink   (input valid, sec_byte, sec_valid, sec_first, done_res, status,
                  output ready);
endinterface

interface tlvse_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [20:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: design/tlvse_cfg_regs.sv
// ---------------------------------------------------------------------------
// tlvse_cfg_regs: configuration register file
// Holds version, security tag, critical mask and size limit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tlvse_cfg_regs (
  input  wire                 clk,
  input  wire                 rst,
  tlvse_cfg_if.sink           cfg,
  output tlvse_pkg::cfg_regs_t regs
);
  import tlvse_pkg::*;

  logic wr;

  assign cfg.ready = 1'b1;
  assign wr        = cfg.valid && cfg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.expected_version <= 16'd1;
      regs.security_tag     <= 16'd1;
      regs.critical_mask    <= 16'h8000;
      regs.max_bytes        <= PosW'(65536);
    end else if (wr) begin
      case (cfg.index)
        CFG_EXPECTED_VERSION: regs.expected_version <= cfg.data[15:0];
        CFG_SECURITY_TAG:     regs.security_tag     <= cfg.data[15:0];
        CFG_CRITICAL_MASK:    regs.critical_mask    <= cfg.data[15:0];
        CFG_MAX_BYTES:        regs.max_bytes        <= cfg.data[PosW-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/tlvse_parser.sv
// ---------------------------------------------------------------------------
// tlvse_parser: per-byte section parser
// Updates the parse state on each input beat and forms the result record.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tlvse_parser (
  input  wire                  clk,
  input  wire                  rst,
  tlvse_byte_if.sink           blob,
  input  tlvse_pkg::cfg_regs_t regs,
  input  wire                  buf_ready,
  output logic                 res_push,
  output tlvse_pkg::result_t   res
);
  import tlvse_pkg::*;

  localparam logic [1:0] PH_ENV    = 2'd0;
  localparam logic [1:0] PH_SECHDR = 2'd1;
  localparam logic [1:0] PH_BODY   = 2'd2;

  logic [PosW-1:0] pos, pos_next;
  logic            over_limit, over_limit_next;
  logic [2:0]      first_error, first_error_next;
  logic [1:0]      phase, phase_next;
  logic [2:0]      hdr_cnt, hdr_cnt_next;
  logic [55:0]     shift, shift_next;
  logic [31:0]     body_left, body_left_next;
  logic            in_sec, in_sec_next;
  logic            crit_pend, crit_pend_next;
  logic            first_due, first_due_next;

  logic        beat, emit, first, done;
  logic [2:0]  st;
  logic [15:0] w0, w1, tag_id;
  logic [31:0] w2;
  logic        crit;

  assign blob.ready = buf_ready;
  assign beat       = blob.valid && blob.ready;

  // header words; the incoming byte completes the length word
  assign w0     = shift[15:0];
  assign w1     = shift[31:16];
  assign w2     = {blob.byte_value, shift[55:32]};
  assign tag_id = w0 & ~regs.critical_mask;
  assign crit   = (w0 & regs.critical_mask) != 16'd0;

  always_comb begin
    pos_next         = pos;
    over_limit_next  = over_limit;
    first_error_next = first_error;
    phase_next       = phase;
    hdr_cnt_next     = hdr_cnt;
    shift_next       = shift;
    body_left_next   = body_left;
    in_sec_next      = in_sec;
    crit_pend_next   = crit_pend;
    first_due_next   = first_due;
    emit             = 1'b0;
    first            = 1'b0;
    done             = 1'b1;
    st               = ST_OK;

    if (!blob.empty_blob) begin
      done = blob.last_byte;
      if (pos >= regs.max_bytes) over_limit_next = 1'b1;
      if (pos != PosMax) pos_next = pos + 1'b1;
      if (!over_limit_next && first_error == ST_OK) begin
        if (phase == PH_BODY) begin
          emit           = in_sec;
          body_left_next = body_left - 32'd1;
          if (body_left == 32'd1) begin
            if (crit_pend) first_error_next = ST_CRITICAL;
            phase_next     = PH_SECHDR;
            in_sec_next    = 1'b0;
            crit_pend_next = 1'b0;
          end
        end else if (hdr_cnt != 3'd7) begin
          shift_next[8*hdr_cnt +: 8] = blob.byte_value;
          hdr_cnt_next               = hdr_cnt + 3'd1;
        end else begin
          hdr_cnt_next = 3'd0;
          if (phase == PH_ENV) begin
            if (w0 != regs.expected_version || w1 != 16'd0) first_error_next = ST_VERSION;
            else phase_next = PH_SECHDR;
          end else if (w1 != 16'd0) begin
            first_error_next = ST_SECTION;
          end else if (tag_id == regs.security_tag) begin
            if (w2 == 32'd0) begin
              first_error_next = ST_SEC_EMPTY;
            end else begin
              phase_next     = PH_BODY;
              in_sec_next    = 1'b1;
              crit_pend_next = 1'b0;
              first_due_next = 1'b1;
              body_left_next = w2;
            end
          end else if (w2 == 32'd0) begin
            if (crit) first_error_next = ST_CRITICAL;
          end else begin
            phase_next     = PH_BODY;
            in_sec_next    = 1'b0;
            crit_pend_next = crit;
            body_left_next = w2;
          end
        end
        if (emit) begin
          first          = first_due;
          first_due_next = 1'b0;
        end
      end
    end

    // final status from the updated state
    if (done) begin
      if (over_limit_next) st = ST_ENV_INVALID;
      else if (pos_next == '0) st = ST_OK;
      else if (pos_next < PosW'(HdrBytes)) st = ST_ENV_INVALID;
      else if (first_error_next != ST_OK) st = first_error_next;
      else if (phase_next == PH_SECHDR && hdr_cnt_next != 3'd0) st = ST_TRUNCATED;
      else if (phase_next == PH_BODY && body_left_next != 32'd0) st = ST_SECTION;
      else st = ST_OK;
      if (st != ST_OK) begin
        emit  = 1'b0;
        first = 1'b0;
      end
    end
  end

  assign res_push      = beat && (emit || done);
  assign res.sec_byte  = emit ? blob.byte_value : 8'd0;
  assign res.sec_valid = emit;
  assign res.sec_first = first;
  assign res.done_res  = done;
  assign res.status    = st;

  always_ff @(posedge clk) begin
    if (rst || (beat && done)) begin
      pos         <= '0;
      over_limit  <= 1'b0;
      first_error <= ST_OK;
      phase       <= PH_ENV;
      hdr_cnt     <= 3'd0;
      body_left   <= 32'd0;
      in_sec      <= 1'b0;
      crit_pend   <= 1'b0;
      first_due   <= 1'b0;
    end else if (beat) begin
      pos         <= pos_next;
      over_limit  <= over_limit_next;
      first_error <= first_error_next;
      phase       <= phase_next;
      hdr_cnt     <= hdr_cnt_next;
      body_left   <= body_left_next;
      in_sec      <= in_sec_next;
      crit_pend   <= crit_pend_next;
      first_due   <= first_due_next;
    end
  end

  // header byte slots are always rewritten before they are read
  always_ff @(posedge clk) begin
    if (beat) shift <= shift_next;
  end

endmodule

`default_nettype wire

// File: design/tlvse_out_buf.sv
// ---------------------------------------------------------------------------
// tlvse_out_buf: two-entry result skid buffer
// Registers results; input keeps flowing through a sink stall until both are full.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tlvse_out_buf (
  input  wire                clk,
  input  wire                rst,
  input  wire                push,
  input  tlvse_pkg::result_t din,
  output logic               can_take,
  tlvse_res_if.source        out
);
  import tlvse_pkg::*;

  logic [1:0] count;
  result_t    slot0, slot1;
  logic       pop;

  assign can_take = (count != 2'd2);
  assign pop      = out.valid && out.ready;

  assign out.valid     = (count != 2'd0);
  assign out.sec_byte  = slot0.sec_byte;
  assign out.sec_valid = slot0.sec_valid;
  assign out.sec_first = slot0.sec_first;
  assign out.done_res  = slot0.done_res;
  assign out.status    = slot0.status;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (count == 2'd0) slot0 <= din;
        else slot1 <= din;
      end
      2'b01: slot0 <= slot1;
      2'b11: begin
        if (count == 2'd1) begin
          slot0 <= din;
        end else begin
          slot0 <= slot1;
          slot1 <= din;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: design/tlv_envelope_section_extractor.sv
// ---------------------------------------------------------------------------
// tlv_envelope_section_extractor: tagged metadata blob parser
// Checks envelope and section headers byte by byte and streams out the
// security section body with a final status on the last byte.
// ---------------------------------------------------------------------------
//  channel  dir  payload                                         handshake
//  blob     in   byte_value, last_byte, empty_blob               valid/ready
//  result   out  sec_byte, sec_valid, sec_first, done_res, status valid/ready
//  cfg      in   index, data                                     valid/ready
//
// One byte per cycle; a result lands in the output buffer the cycle after
// its beat. Two result slots decouple the sides: blob stalls only while both
// are full. Bytes that give no result are still accepted. Reset clears the
// parse state and loads register defaults; cfg is always ready.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tlv_envelope_section_extractor (
  input  wire         clk,
  input  wire         rst,
  tlvse_byte_if.sink  blob,
  tlvse_res_if.source result,
  tlvse_cfg_if.sink   cfg
);
  import tlvse_pkg::*;

  cfg_regs_t regs;
  result_t   res;
  logic      res_push;
  logic      buf_ready;

  tlvse_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  tlvse_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .blob      (blob),
    .regs      (regs),
    .buf_ready (buf_ready),
    .res_push  (res_push),
    .res       (res)
  );

  tlvse_out_buf u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (res_push),
    .din      (res),
    .can_take (buf_ready),
    .out      (result)
  );

endmodule

`default_nettype wire
